// ----- hw/rtl/days_between_dates_macros.svh -----
// Assertion macros shared by the verification files of the date difference block.
// Depends on nothing; every use expects clk_i and rst_ni in scope.
`ifndef DAYS_BETWEEN_DATES_MACROS_SVH
`define DAYS_BETWEEN_DATES_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dbd_pkg.sv -----
// Package for the date difference block: field widths, calendar constants and
// the month length function. Depends on nothing.
`timescale 1ns / 1ps

package dbd_pkg;

  localparam int YearW  = 14;
  localparam int MonW   = 4;
  localparam int DayW   = 5;
  localparam int CountW = 22;
  localparam int R400W  = 9;
  localparam int QuotW  = 6;
  localparam int RecipW = 13;
  localparam int RecipShift = 21;

  localparam logic [YearW-1:0]  YearMax = 14'd9999;
  localparam logic [MonW-1:0]   MonJan  = 4'd1;
  localparam logic [MonW-1:0]   MonFeb  = 4'd2;
  localparam logic [MonW-1:0]   MonApr  = 4'd4;
  localparam logic [MonW-1:0]   MonJun  = 4'd6;
  localparam logic [MonW-1:0]   MonSep  = 4'd9;
  localparam logic [MonW-1:0]   MonNov  = 4'd11;
  localparam logic [MonW-1:0]   MonDec  = 4'd12;
  localparam logic [DayW-1:0]   DayFirst = 5'd1;

  // floor(y / 400) equals (y * RecipMul) >> RecipShift for every 14-bit y.
  localparam logic [RecipW-1:0] RecipMul = 13'd5243;
  localparam logic [R400W-1:0]  Quad400  = 9'd400;
  localparam logic [R400W-1:0]  Last400  = 9'd399;
  localparam logic [R400W-1:0]  Cent1    = 9'd100;
  localparam logic [R400W-1:0]  Cent2    = 9'd200;
  localparam logic [R400W-1:0]  Cent3    = 9'd300;

  // Leap rule from the year modulo 400.
  function automatic logic leap_from_r400(input logic [R400W-1:0] r);
    logic cent;
    cent = (r == Cent1) || (r == Cent2) || (r == Cent3);
    return (r == '0) || (!cent && (r[1:0] == 2'b00));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    case (m) inside
      MonFeb:                         len = leap ? 5'd29 : 5'd28;
      MonApr, MonJun, MonSep, MonNov: len = 5'd30;
      default:                        len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/dbd_in_if.sv -----
// Input channel of the date difference block: handshake and the two dates.
// Depends on dbd_pkg.
`timescale 1ns / 1ps

interface dbd_in_if import dbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [YearW-1:0] start_year;
  logic [MonW-1:0]  start_month;
  logic [DayW-1:0]  start_day;
  logic [YearW-1:0] end_year;
  logic [MonW-1:0]  end_month;
  logic [DayW-1:0]  end_day;

  modport source (output valid, start_year, start_month, start_day,
                  end_year, end_month, end_day, input ready);
  modport sink   (input valid, start_year, start_month, start_day,
                  end_year, end_month, end_day, output ready);
endinterface

// ----- hw/rtl/dbd_out_if.sv -----
// Output channel of the date difference block: handshake, day count and flag.
// Depends on dbd_pkg.
`timescale 1ns / 1ps

interface dbd_out_if import dbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] day_count;
  logic              invalid;

  modport source (output valid, day_count, invalid, input ready);
  modport sink   (input valid, day_count, invalid, output ready);
endinterface

// ----- hw/rtl/dbd_year_unit.sv -----
// Two-stage year residue unit: year modulo 400 through a reciprocal multiply.
// Depends on dbd_pkg.
`timescale 1ns / 1ps

module dbd_year_unit import dbd_pkg::*; (
  input  logic             clk_i,
  input  logic [YearW-1:0] year_i,
  output logic [R400W-1:0] r400_o
);

  logic [YearW+RecipW-1:0] prod;
  logic [QuotW-1:0]        quot_q;
  logic [YearW:0]          rem;

  assign prod = {{RecipW{1'b0}}, year_i} * {{YearW{1'b0}}, RecipMul};

  // The year must be held for both cycles: the quotient is taken in the first,
  // the remainder in the second.
  assign rem = {1'b0, year_i} - ((YearW+1)'(quot_q) * (YearW+1)'(Quad400));

  always_ff @(posedge clk_i) begin
    quot_q <= prod[RecipShift +: QuotW];
    r400_o <= rem[R400W-1:0];
  end

endmodule

// ----- hw/rtl/days_between_dates.sv -----
// Top level of the date difference block: sequencer, date stepper and output
// register. Depends on dbd_pkg, dbd_in_if, dbd_out_if and dbd_year_unit.
//
// Use: a transfer on in_i carries two Gregorian dates in either order. The
// block puts them in order, checks both against the calendar and then steps
// the earlier date forward one day per cycle until it equals the later one.
// One transfer on out_o returns the day count and the invalid flag; an
// invalid date gives invalid = 1 and a count of zero.
// Sequence: two passes through the year residue unit and the calendar check
// (states S_MUL, S_REM and S_CHK), first for the later date and then for the
// earlier one; then one S_STEP per day of difference plus one that sees the
// dates meet, and S_DONE to load the output register. The difference is at
// most 3652058 days; an invalid date skips the stepping.
// in_i.ready is high only while the sequencer is idle; one item is in work at
// a time. A finished result waits in the output register while out_o.ready is
// low, and the next item may be accepted meanwhile; its result is held in the
// sequencer until the register frees up.
// Reset clears the sequencer and the output valid; no result is pending after it.
`timescale 1ns / 1ps

module days_between_dates import dbd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  dbd_in_if.sink   in_i,
  dbd_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_REM,
    S_CHK,
    S_STEP,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic              chk_tgt_q, chk_tgt_d;
  logic              bad_q, bad_d;
  logic [YearW-1:0]  cur_y_q, cur_y_d, tgt_y_q, tgt_y_d;
  logic [MonW-1:0]   cur_m_q, cur_m_d, tgt_m_q, tgt_m_d;
  logic [DayW-1:0]   cur_d_q, cur_d_d, tgt_d_q, tgt_d_d;
  logic [R400W-1:0]  cur_r_q, cur_r_d;
  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] out_count_q, out_count_d;
  logic              out_invalid_q, out_invalid_d;

  logic              in_xfer;
  logic              swap;
  logic [YearW-1:0]  unit_year;
  logic [R400W-1:0]  unit_r400;
  logic [YearW-1:0]  chk_y;
  logic [MonW-1:0]   chk_m;
  logic [DayW-1:0]   chk_d;
  logic              chk_ok;
  logic              cur_leap;
  logic              at_target;
  logic              out_free;

  assign in_i.ready    = (state_q == S_IDLE);
  assign in_xfer       = in_i.valid && in_i.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.day_count = out_count_q;
  assign out_o.invalid   = out_invalid_q;

  assign swap = {in_i.start_year, in_i.start_month, in_i.start_day} >
                {in_i.end_year, in_i.end_month, in_i.end_day};

  assign unit_year = chk_tgt_q ? tgt_y_q : cur_y_q;

  dbd_year_unit u_year (
    .clk_i  (clk_i),
    .year_i (unit_year),
    .r400_o (unit_r400)
  );

  assign chk_y  = unit_year;
  assign chk_m  = chk_tgt_q ? tgt_m_q : cur_m_q;
  assign chk_d  = chk_tgt_q ? tgt_d_q : cur_d_q;
  assign chk_ok = (chk_y != '0) && (chk_y <= YearMax) &&
                  (chk_m != '0) && (chk_m <= MonDec) &&
                  (chk_d != '0) && (chk_d <= month_len(chk_m, leap_from_r400(unit_r400)));

  assign cur_leap  = leap_from_r400(cur_r_q);
  assign at_target = (cur_y_q == tgt_y_q) && (cur_m_q == tgt_m_q) && (cur_d_q == tgt_d_q);
  assign out_free  = !out_valid_q || out_o.ready;

  always_comb begin
    state_d       = state_q;
    chk_tgt_d     = chk_tgt_q;
    bad_d         = bad_q;
    cur_y_d       = cur_y_q;
    cur_m_d       = cur_m_q;
    cur_d_d       = cur_d_q;
    tgt_y_d       = tgt_y_q;
    tgt_m_d       = tgt_m_q;
    tgt_d_d       = tgt_d_q;
    cur_r_d       = cur_r_q;
    count_d       = count_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_count_d   = out_count_q;
    out_invalid_d = out_invalid_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          // The earlier date becomes the stepping date.
          if (swap) begin
            cur_y_d = in_i.end_year;
            cur_m_d = in_i.end_month;
            cur_d_d = in_i.end_day;
            tgt_y_d = in_i.start_year;
            tgt_m_d = in_i.start_month;
            tgt_d_d = in_i.start_day;
          end else begin
            cur_y_d = in_i.start_year;
            cur_m_d = in_i.start_month;
            cur_d_d = in_i.start_day;
            tgt_y_d = in_i.end_year;
            tgt_m_d = in_i.end_month;
            tgt_d_d = in_i.end_day;
          end
          chk_tgt_d = 1'b1;
          state_d   = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_REM;
      end
      S_REM: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (chk_tgt_q) begin
          bad_d     = !chk_ok;
          chk_tgt_d = 1'b0;
          state_d   = S_MUL;
        end else begin
          bad_d   = bad_q || !chk_ok;
          cur_r_d = unit_r400;
          count_d = '0;
          state_d = (bad_q || !chk_ok) ? S_DONE : S_STEP;
        end
      end
      S_STEP: begin
        if (at_target) begin
          state_d = S_DONE;
        end else begin
          count_d = count_q + 1'b1;
          if (cur_d_q == month_len(cur_m_q, cur_leap)) begin
            cur_d_d = DayFirst;
            if (cur_m_q == MonDec) begin
              cur_m_d = MonJan;
              cur_y_d = cur_y_q + 1'b1;
              cur_r_d = (cur_r_q == Last400) ? '0 : cur_r_q + 1'b1;
            end else begin
              cur_m_d = cur_m_q + 1'b1;
            end
          end else begin
            cur_d_d = cur_d_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_count_d   = count_q;
          out_invalid_d = bad_q;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      chk_tgt_q     <= 1'b0;
      bad_q         <= 1'b0;
      cur_y_q       <= '0;
      cur_m_q       <= '0;
      cur_d_q       <= '0;
      tgt_y_q       <= '0;
      tgt_m_q       <= '0;
      tgt_d_q       <= '0;
      cur_r_q       <= '0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      out_count_q   <= '0;
      out_invalid_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      chk_tgt_q     <= chk_tgt_d;
      bad_q         <= bad_d;
      cur_y_q       <= cur_y_d;
      cur_m_q       <= cur_m_d;
      cur_d_q       <= cur_d_d;
      tgt_y_q       <= tgt_y_d;
      tgt_m_q       <= tgt_m_d;
      tgt_d_q       <= tgt_d_d;
      cur_r_q       <= cur_r_d;
      count_q       <= count_d;
      out_valid_q   <= out_valid_d;
      out_count_q   <= out_count_d;
      out_invalid_q <= out_invalid_d;
    end
  end

endmodule

// ----- hw/rtl/dbd_checker.sv -----
// Port-level checker for the date difference block, bound to the top level.
// Depends on dbd_pkg and days_between_dates_macros.svh.
`timescale 1ns / 1ps
`include "days_between_dates_macros.svh"

module dbd_checker import dbd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [CountW-1:0] day_count_i,
  input logic              invalid_i
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // An invalid date never comes with a nonzero count.
  `DBD_ASSERT_NOW(a_invalid_zero, out_valid_i && invalid_i, day_count_i == '0, "invalid count")
  // One item at a time: the block is busy right after an input transfer.
  `DBD_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_ready_i, "input accepted while busy")
  // A stalled result stays offered.
  `DBD_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i, "result dropped under stall")
  // A stalled result keeps its payload.
  `DBD_ASSERT_NEXT(a_out_stable, out_stall, $stable({day_count_i, invalid_i}), "result changed")

endmodule

bind days_between_dates dbd_checker u_dbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .day_count_i (out_o.day_count),
  .invalid_i   (out_o.invalid)
);
